FILE: src/sha256_pkg.sv
// Shared types, constants and round functions of the SHA-256 engine.
package sha256_pkg;

	// Block geometry.
	localparam int BLK_BYTES = 64;
	localparam int BLK_BITS = BLK_BYTES * 8;
	localparam int WORD_BITS = 32;
	localparam int BLK_WORDS = BLK_BITS / WORD_BITS;
	localparam int CHAIN_WORDS = 8;
	localparam int LEN_BITS = 64;

	// Block queue geometry.
	localparam int FIFO_AW = 1;
	localparam int FIFO_DEPTH = 2 ** FIFO_AW;

	// Input opcodes carried on tuser.
	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	// Padding constants.
	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] PAD_LAST_ZERO = 6'd55;
	localparam logic [5:0] BLK_LAST_BYTE = 6'd63;
	localparam logic [5:0] LAST_ROUND = 6'd63;
	localparam logic [LEN_BITS-1:0] BLK_BIT_COUNT = LEN_BITS'(BLK_BITS);

	// Initial hash values, word 0 in the lowest slot.
	localparam logic [CHAIN_WORDS-1:0][WORD_BITS-1:0] IV = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	// One full message block on its way to the round unit.
	typedef struct packed {
		logic last;
		logic [BLK_BITS-1:0] data;
	} blk_entry_t;

	// Queue status seen by the producer and the consumer.
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	// Round constants.
	function automatic logic [31:0] k_const(input logic [5:0] idx);
		logic [31:0] k;
		unique case (idx)
			6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
			6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
			6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
			6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		k_const = k;
	endfunction

endpackage

FILE: src/sha256_front.sv
// Front end: accepts bytes, builds 64-byte blocks and inserts the padding.
module sha256_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [7:0]              s_tdata,   // [7:0] data_byte
	input  logic                    s_tuser,   // [0] opcode
	output logic                    push,
	output sha256_pkg::blk_entry_t  push_entry,
	input  sha256_pkg::fifo_stat_t  fifo_stat
);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_MARK = 2'd1;
	localparam logic [1:0] F_ZERO = 2'd2;
	localparam logic [1:0] F_LEN  = 2'd3;

	logic [1:0]                        state_q;
	logic [5:0]                        cnt_q;
	logic [sha256_pkg::LEN_BITS-1:0]   bits_q;
	logic [sha256_pkg::LEN_BITS-1:0]   len_q;
	logic [sha256_pkg::BLK_BITS-1:0]   blk_q;
	logic [sha256_pkg::BLK_BITS-1:0]   blk_next;
	logic                              blk_end;
	logic                              stall;
	logic                              in_xfer;
	logic                              finish;
	logic                              shift_en;
	logic [7:0]                        sh_byte;

	// The byte that closes a block needs a free queue slot.
	assign blk_end = (cnt_q == sha256_pkg::BLK_LAST_BYTE);
	assign stall = blk_end && fifo_stat.full;
	assign s_tready = (state_q == F_IDLE) && !stall;
	assign in_xfer = s_tvalid && s_tready;
	assign finish = in_xfer && (s_tuser == sha256_pkg::OP_FINISH);

	// Pick the byte that enters the block shift line this cycle.
	always_comb begin
		unique case (state_q)
			F_IDLE: begin
				shift_en = in_xfer && (s_tuser == sha256_pkg::OP_APPEND);
				sh_byte = s_tdata;
			end
			F_MARK: begin
				shift_en = !stall;
				sh_byte = sha256_pkg::PAD_MARK;
			end
			F_ZERO: begin
				shift_en = !stall;
				sh_byte = 8'h00;
			end
			F_LEN: begin
				shift_en = !stall;
				sh_byte = len_q[sha256_pkg::LEN_BITS-1 -: 8];
			end
			default: begin
				shift_en = 1'b0;
				sh_byte = 8'h00;
			end
		endcase
	end

	// The first byte of the block ends up in the top bits.
	assign blk_next = {blk_q[sha256_pkg::BLK_BITS-9:0], sh_byte};
	assign push = shift_en && blk_end;
	assign push_entry.data = blk_next;
	assign push_entry.last = (state_q == F_LEN);

	// Block shift line and length shifter.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			blk_q <= blk_next;
		end
		if (finish) begin
			len_q <= bits_q + {{(sha256_pkg::LEN_BITS-9){1'b0}}, cnt_q, 3'b000};
		end else if (shift_en && (state_q == F_LEN)) begin
			len_q <= {len_q[sha256_pkg::LEN_BITS-9:0], 8'h00};
		end
	end

	// Byte count, bit count and padding sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q <= '0;
			bits_q <= '0;
		end else begin
			if (shift_en) begin
				cnt_q <= cnt_q + 6'd1;
			end
			if (push && (state_q == F_IDLE)) begin
				bits_q <= bits_q + sha256_pkg::BLK_BIT_COUNT;
			end else if (push) begin
				bits_q <= '0;
			end
			unique case (state_q)
				F_IDLE: begin
					if (finish) begin
						state_q <= F_MARK;
					end
				end
				F_MARK: begin
					if (shift_en) begin
						state_q <= (cnt_q == sha256_pkg::PAD_LAST_ZERO) ? F_LEN : F_ZERO;
					end
				end
				F_ZERO: begin
					if (shift_en && (cnt_q == sha256_pkg::PAD_LAST_ZERO)) begin
						state_q <= F_LEN;
					end
				end
				F_LEN: begin
					if (push) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

FILE: src/sha256_blk_fifo.sv
// Two-entry block queue between the front end and the round unit.
module sha256_blk_fifo (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  sha256_pkg::blk_entry_t  push_entry,
	input  logic                    pop,
	output sha256_pkg::blk_entry_t  pop_entry,
	output sha256_pkg::fifo_stat_t  stat
);

	sha256_pkg::blk_entry_t         mem_q [sha256_pkg::FIFO_DEPTH];
	logic [sha256_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [sha256_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [sha256_pkg::FIFO_AW:0]   cnt_q;

	assign stat.full = (cnt_q == (sha256_pkg::FIFO_AW+1)'(sha256_pkg::FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign pop_entry = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/sha256_back.sv
// Back end: 64-round compression, chaining words and digest output register.
module sha256_back (
	input  logic                    clk,
	input  logic                    arst_n,
	output logic                    pop,
	input  sha256_pkg::blk_entry_t  pop_entry,
	input  sha256_pkg::fifo_stat_t  fifo_stat,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [31:0]             m_tdata,   // [31:0] digest_word
	output logic                    m_tlast    // last_word
);

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_RUN  = 2'd1;
	localparam logic [1:0] B_ADD  = 2'd2;
	localparam logic [1:0] B_OUT  = 2'd3;

	logic [1:0]  state_q;
	logic [5:0]  rnd_q;
	logic        last_q;
	logic [2:0]  out_idx_q;
	logic [31:0] win_q [sha256_pkg::BLK_WORDS];
	logic [31:0] v_q [sha256_pkg::CHAIN_WORDS];
	logic [31:0] chain_q [sha256_pkg::CHAIN_WORDS];
	logic        m_tvalid_q;
	logic [31:0] m_tdata_q;
	logic        m_tlast_q;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] w_new;
	logic        load;

	assign pop = (state_q == B_IDLE) && !fifo_stat.empty;
	assign load = (state_q == B_OUT) && (!m_tvalid_q || m_tready);

	// One round of the compression and one step of the message schedule.
	always_comb begin
		t1 = v_q[7] + sha256_pkg::bsig1(v_q[4])
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ sha256_pkg::k_const(rnd_q) + win_q[0];
		t2 = sha256_pkg::bsig0(v_q[0])
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		w_new = sha256_pkg::ssig1(win_q[14]) + win_q[9]
			+ sha256_pkg::ssig0(win_q[1]) + win_q[0];
	end

	// Working variables and schedule window.
	always_ff @(posedge clk) begin
		if (pop) begin
			for (int i = 0; i < sha256_pkg::BLK_WORDS; i++) begin
				win_q[i] <= pop_entry.data[sha256_pkg::BLK_BITS-1-32*i -: 32];
			end
			for (int i = 0; i < sha256_pkg::CHAIN_WORDS; i++) begin
				v_q[i] <= chain_q[i];
			end
			last_q <= pop_entry.last;
		end else if (state_q == B_RUN) begin
			for (int i = 0; i < sha256_pkg::BLK_WORDS - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[sha256_pkg::BLK_WORDS-1] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		if (load) begin
			m_tdata_q <= chain_q[out_idx_q];
			m_tlast_q <= (out_idx_q == 3'd7);
		end
	end

	// Sequencer, chaining words and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			rnd_q <= '0;
			out_idx_q <= '0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < sha256_pkg::CHAIN_WORDS; i++) begin
				chain_q[i] <= sha256_pkg::IV[i];
			end
		end else begin
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						state_q <= B_RUN;
						rnd_q <= '0;
					end
				end
				B_RUN: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == sha256_pkg::LAST_ROUND) begin
						state_q <= B_ADD;
					end
				end
				B_ADD: begin
					for (int i = 0; i < sha256_pkg::CHAIN_WORDS; i++) begin
						chain_q[i] <= chain_q[i] + v_q[i];
					end
					out_idx_q <= '0;
					state_q <= last_q ? B_OUT : B_IDLE;
				end
				B_OUT: begin
					if (load) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (out_idx_q == 3'd7) begin
							state_q <= B_IDLE;
							for (int i = 0; i < sha256_pkg::CHAIN_WORDS; i++) begin
								chain_q[i] <= sha256_pkg::IV[i];
							end
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tlast = m_tlast_q;

`ifndef SYNTH
	// The final add follows the last round directly.
	a_add_after_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_ADD) |-> ($past(state_q) == B_RUN && $past(rnd_q) == sha256_pkg::LAST_ROUND))
		else $error("final add without a full set of rounds");

	// Digest output happens only for the final block of a message.
	a_out_last_blk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_OUT) |-> last_q)
		else $error("digest output for an inner block");

	// After the eighth word is loaded the chaining words restart.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(load && out_idx_q == 3'd7) |=>
			(state_q == B_IDLE && chain_q[0] == sha256_pkg::IV[0] && m_tlast_q))
		else $error("engine did not restart after the digest");
`endif

endmodule

FILE: src/sha256_hash_engine_unit.sv
// Top level of the streaming SHA-256 engine: front end, block queue and round unit.
// A finish pads with the mark byte, zero bytes and the eight length bytes, spilling into
// one more block if the block already holds 56 or more bytes. Per block the round unit
// takes the entry from the queue, runs the 64 rounds and adds into the chaining words.
// Throughput: bytes enter at one per cycle while the two-entry block queue has room and no
// padding runs; the single round unit sets the sustained rate, one block at a time.
// Reset: arst_n clears all control state and loads the initial hash values at once.
module sha256_hash_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic        m_tlast    // last_word
);

	logic                   push;
	logic                   pop;
	sha256_pkg::blk_entry_t push_entry;
	sha256_pkg::blk_entry_t pop_entry;
	sha256_pkg::fifo_stat_t fifo_stat;

	// Byte intake and padding.
	sha256_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push       (push),
		.push_entry (push_entry),
		.fifo_stat  (fifo_stat)
	);

	// Block queue.
	sha256_blk_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.stat       (fifo_stat)
	);

	// Compression and digest output.
	sha256_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.fifo_stat  (fifo_stat),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule
